// ===== sv/cpm_pkg.sv =====
// Shared constants and types for the capture pulse measurement block.
// No dependencies; every other file refers to this package by scoped names.
package cpm_pkg;

   localparam int CAP_W      = 16;
   localparam int OVF_W      = 16;
   localparam int RELOAD_W   = 16;
   localparam int STAMP_W    = 32;
   localparam int INTERVAL_W = 17;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   // Register indexes on the configuration channel
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASURE_MODE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELOAD_PERIOD = 1'd1;

   localparam logic MODE_SIMPLE  = 1'b0;
   localparam logic MODE_COMPLEX = 1'b1;

   localparam logic [RELOAD_W-1:0]   RELOAD_RESET  = 16'hFFFF;
   // Interval reported when two simple-mode stamps are equal: one full wrap
   localparam logic [INTERVAL_W-1:0] INTERVAL_WRAP = 17'h10000;

   // Extended stamp moving from the multiply stage to the tracking stage
   typedef struct packed {
      logic               valid;
      logic [STAMP_W-1:0] stamp;
   } stamp_beat_type;

endpackage

// ===== sv/cpm_ifs.sv =====
// Handshake channel interfaces: capture request, measurement response, register write.
// Depends on cpm_pkg for field widths.
interface cpm_req_if;
   logic                      valid;
   logic                      ready;
   logic [cpm_pkg::CAP_W-1:0] capture_value;
   logic [cpm_pkg::OVF_W-1:0] overflow_count;

   modport source (output valid, output capture_value, output overflow_count, input ready);
   modport sink   (input valid, input capture_value, input overflow_count, output ready);
endinterface

interface cpm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cpm_pkg::INTERVAL_W-1:0] interval_ticks;
   logic [cpm_pkg::STAMP_W-1:0]    high_ticks;
   logic [cpm_pkg::STAMP_W-1:0]    low_ticks;
   logic                           data_ready;
   logic                           watch_falling;

   modport source (output valid, output interval_ticks, output high_ticks,
                   output low_ticks, output data_ready, output watch_falling,
                   input ready);
   modport sink   (input valid, input interval_ticks, input high_ticks,
                   input low_ticks, input data_ready, input watch_falling,
                   output ready);
endinterface

interface cpm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cpm_pkg::CSR_INDEX_W-1:0] index;
   logic [cpm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/cpm_stamp.sv =====
// Input register and stamp stage: complex stamp = capture + overflows * reload.
// Depends on cpm_pkg and cpm_req_if.
module cpm_stamp (
   input  logic                          clock,
   input  logic                          reset,
   cpm_req_if.sink                       req_chan,
   input  logic                          measure_mode,
   input  logic [cpm_pkg::RELOAD_W-1:0]  reload_period,
   output cpm_pkg::stamp_beat_type       beat,
   input  logic                          beat_ready
);

   logic                      s1_valid_ff, s1_valid_in;
   logic [cpm_pkg::CAP_W-1:0] cap_ff;
   logic [cpm_pkg::OVF_W-1:0] ovf_ff;

   logic                        s2_valid_ff, s2_valid_in;
   logic [cpm_pkg::STAMP_W-1:0] stamp_ff, stamp_in;

   logic s1_free, s2_free;
   logic [cpm_pkg::STAMP_W-1:0] product;

   assign s2_free        = !s2_valid_ff || beat_ready;
   assign s1_free        = !s1_valid_ff || s2_free;
   assign req_chan.ready = s1_free;

   assign s1_valid_in = s1_free ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   // Simple mode tracks the raw counter value; complex mode extends it
   assign product = cpm_pkg::STAMP_W'(ovf_ff) * cpm_pkg::STAMP_W'(reload_period);
   always_comb begin
      if (measure_mode == cpm_pkg::MODE_COMPLEX) begin
         stamp_in = product + cpm_pkg::STAMP_W'(cap_ff);
      end else begin
         stamp_in = cpm_pkg::STAMP_W'(cap_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload: load on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (req_chan.valid && s1_free) begin
         cap_ff <= req_chan.capture_value;
         ovf_ff <= req_chan.overflow_count;
      end
      if (s1_valid_ff && s2_free) begin
         stamp_ff <= stamp_in;
      end
   end

   assign beat.valid = s2_valid_ff;
   assign beat.stamp = stamp_ff;

endmodule

// ===== sv/cpm_track.sv =====
// Measurement state update and result register: interval, high/low times, ready, edge.
// Depends on cpm_pkg and cpm_rsp_if; fed by cpm_stamp.
module cpm_track (
   input  logic                    clock,
   input  logic                    reset,
   input  cpm_pkg::stamp_beat_type beat,
   output logic                    beat_ready,
   input  logic                    measure_mode,
   cpm_rsp_if.source               rsp_chan
);

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [cpm_pkg::STAMP_W-1:0]    prev_ff, prev_in;
   logic [cpm_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [cpm_pkg::STAMP_W-1:0]    high_ff, high_in;
   logic [cpm_pkg::STAMP_W-1:0]    low_ff, low_in;
   logic                           ready_ff, ready_in;
   logic                           edge_ff, edge_in;

   logic                        out_free, upd, same_stamp;
   logic [cpm_pkg::CAP_W-1:0]   diff16;
   logic [cpm_pkg::STAMP_W-1:0] span;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign beat_ready = out_free;
   assign upd        = beat.valid && out_free;

   assign same_stamp = (beat.stamp == prev_ff);
   assign span       = beat.stamp - prev_ff;
   assign diff16     = beat.stamp[cpm_pkg::CAP_W-1:0] - prev_ff[cpm_pkg::CAP_W-1:0];

   assign rsp_valid_in = out_free ? beat.valid : rsp_valid_ff;

   always_comb begin
      prev_in     = prev_ff;
      interval_in = interval_ff;
      high_in     = high_ff;
      low_in      = low_ff;
      ready_in    = ready_ff;
      edge_in     = edge_ff;
      if (upd) begin
         if (measure_mode == cpm_pkg::MODE_SIMPLE) begin
            // equal stamps count as a full counter wrap
            interval_in = (diff16 == '0) ? cpm_pkg::INTERVAL_WRAP
                                         : cpm_pkg::INTERVAL_W'(diff16);
            prev_in     = beat.stamp;
            ready_in    = 1'b1;
         end else if (same_stamp) begin
            ready_in = 1'b0;
         end else begin
            prev_in = beat.stamp;
            edge_in = !edge_ff;
            if (edge_ff) begin
               high_in = span;
               if (low_ff != '0) begin
                  ready_in = 1'b1;
               end
            end else begin
               low_in = span;
               if (high_ff != '0) begin
                  ready_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         interval_ff  <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         ready_ff     <= 1'b0;
         edge_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         interval_ff  <= interval_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         ready_ff     <= ready_in;
         edge_ff      <= edge_in;
      end
   end

   // State doubles as the result register: it changes only when a new beat loads
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.interval_ticks = interval_ff;
   assign rsp_chan.high_ticks     = high_ff;
   assign rsp_chan.low_ticks      = low_ff;
   assign rsp_chan.data_ready     = ready_ff;
   assign rsp_chan.watch_falling  = edge_ff;

   a_prev_follows: assert property (@(posedge clock) disable iff (reset)
      upd |=> prev_ff == $past(beat.stamp))
      else $error("previous stamp did not take the new stamp");

   a_simple_nonzero: assert property (@(posedge clock) disable iff (reset)
      upd && measure_mode == cpm_pkg::MODE_SIMPLE |=> interval_ff != '0 && ready_ff)
      else $error("simple interval zero or not ready");

   a_edge_flips: assert property (@(posedge clock) disable iff (reset)
      upd && measure_mode == cpm_pkg::MODE_COMPLEX && !same_stamp
      |=> edge_ff != $past(edge_ff))
      else $error("watched edge did not flip");

   a_equal_clears: assert property (@(posedge clock) disable iff (reset)
      upd && measure_mode == cpm_pkg::MODE_COMPLEX && same_stamp
      |=> !ready_ff && $stable(edge_ff) && $stable(high_ff) && $stable(low_ff))
      else $error("equal stamp did not just clear ready");

   a_no_update_on_stall: assert property (@(posedge clock) disable iff (reset)
      !upd |=> $stable(prev_ff) && $stable(ready_ff) && $stable(edge_ff))
      else $error("state moved without a beat");

endmodule

// ===== sv/capture_pulse_measure_top.sv =====
// Top level of the capture pulse measurement block: register file and stage wiring.
// Depends on cpm_pkg, the channel interfaces, cpm_stamp and cpm_track.

// Each req beat is one capture event (counter value and overflow count); each one
// yields exactly one rsp beat, a snapshot of the measurement state after that event.
// The block takes one beat per cycle while rsp is not stalled; after acceptance
// each beat passes the input register, then the multiply stage that builds the
// extended stamp (capture + overflows * reload in complex mode), then the
// compare/subtract stage whose state registers are also the result register.
// A stalled rsp side backs up stage by stage, so req keeps flowing until all three
// registers hold beats. Write measure_mode and reload_period only while no beat is
// in flight; csr writes are always accepted. In simple mode only the low 16 bits of
// the stamp matter and an equal stamp reports a full wrap of 65536 ticks. In complex
// mode the interval goes to high time after a falling edge and to low time after a
// rising edge, the watched edge then flips, and an equal stamp only clears data_ready.
module capture_pulse_measure_top (
   input  logic       clock,
   input  logic       reset,
   cpm_req_if.sink    req_chan,
   cpm_rsp_if.source  rsp_chan,
   cpm_csr_if.sink    csr_chan
);

   logic                          mode_ff, mode_in;
   logic [cpm_pkg::RELOAD_W-1:0]  reload_ff, reload_in;

   cpm_pkg::stamp_beat_type stamp_beat;
   logic                    stamp_ready;

   // Register writes never stall
   assign csr_chan.ready = 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      reload_in = reload_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            cpm_pkg::CSR_MEASURE_MODE: begin
               mode_in = csr_chan.data[0];
            end
            cpm_pkg::CSR_RELOAD_PERIOD: begin
               reload_in = csr_chan.data;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= cpm_pkg::MODE_SIMPLE;
         reload_ff <= cpm_pkg::RELOAD_RESET;
      end else begin
         mode_ff   <= mode_in;
         reload_ff <= reload_in;
      end
   end

   // Input register plus stamp extension
   cpm_stamp u_stamp (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .measure_mode  (mode_ff),
      .reload_period (reload_ff),
      .beat          (stamp_beat),
      .beat_ready    (stamp_ready)
   );

   // Interval tracking and result register
   cpm_track u_track (
      .clock        (clock),
      .reset        (reset),
      .beat         (stamp_beat),
      .beat_ready   (stamp_ready),
      .measure_mode (mode_ff),
      .rsp_chan     (rsp_chan)
   );

endmodule
